@@ design/assert_macros.svh @@
// Assertion helpers used by the checker file.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define I2P_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("i2p check failed");

// Next-cycle implication, disabled while reset is high.
`define I2P_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("i2p check failed");

`endif

@@ design/i2p_pkg.sv @@
package i2p_pkg;

   // Input token kinds.
   localparam logic [3:0] KIND_OPERAND  = 4'd0;
   localparam logic [3:0] KIND_PLUS     = 4'd1;
   localparam logic [3:0] KIND_INTEGRAL = 4'd6;
   localparam logic [3:0] KIND_OPEN     = 4'd7;
   localparam logic [3:0] KIND_CLOSE    = 4'd8;

   // Operator codes as kept on the stack and sent on the result channel.
   localparam logic [2:0] CODE_OPERAND    = 3'd0;
   localparam logic [2:0] CODE_PLUS       = 3'd1;
   localparam logic [2:0] CODE_MINUS      = 3'd2;
   localparam logic [2:0] CODE_TIMES      = 3'd3;
   localparam logic [2:0] CODE_DIVIDE     = 3'd4;
   localparam logic [2:0] CODE_DERIVATIVE = 3'd5;
   localparam logic [2:0] CODE_INTEGRAL   = 3'd6;
   localparam logic [2:0] CODE_OPEN       = 3'd7;
   localparam logic [2:0] CODE_NONE       = 3'd7;

   // Status codes carried by the final result.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_UNMATCHED = 2'd1;
   localparam logic [1:0] STATUS_UNCLOSED  = 2'd2;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd3;

   // One result item.
   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] value;
      logic        end_of_run;
      logic [1:0]  status;
   } result_type;

   // Command from the sequencer to the output stage.
   typedef struct packed {
      logic       valid;
      logic       finish;
      logic       mark_end;
      result_type item;
   } emit_cmd_type;

   // Operator priority; an open parenthesis ranks below every operator.
   function automatic logic [1:0] prio_of(logic [2:0] code);
      logic [1:0] prio;
      unique case (code)
         CODE_PLUS, CODE_MINUS:           prio = 2'd1;
         CODE_TIMES, CODE_DIVIDE:         prio = 2'd2;
         CODE_DERIVATIVE, CODE_INTEGRAL:  prio = 2'd3;
         default:                         prio = 2'd0;
      endcase
      return prio;
   endfunction

endpackage

@@ design/i2p_if.sv @@
// Token request channel.
interface i2p_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [15:0] operand_value;
   logic        last_token;

   modport source (output valid, token_kind, operand_value, last_token, input ready);
   modport sink (input valid, token_kind, operand_value, last_token, output ready);
endinterface

// Postfix result channel.
interface i2p_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  out_kind;
   logic [15:0] out_value;
   logic        end_of_run;
   logic [1:0]  status_code;

   modport source (output valid, out_kind, out_value, end_of_run, status_code, input ready);
   modport sink (input valid, out_kind, out_value, end_of_run, status_code, output ready);
endinterface

@@ design/i2p_emit.sv @@
// Output stage: a hold slot for the newest result and an output register.
// The newest result waits in the hold slot until it is known whether it ends the run.
module i2p_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  i2p_pkg::emit_cmd_type cmd,
   output logic                 cmd_ready,
   i2p_rsp_if.source            rsp_chan
);

   logic                 hold_valid_ff, hold_valid_in;
   i2p_pkg::result_type  hold_ff, hold_in;
   logic                 out_valid_ff, out_valid_in;
   i2p_pkg::result_type  out_ff, out_in;
   logic                 out_free;
   logic                 out_load;

   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign cmd_ready = !hold_valid_ff || out_free;

   // Move the held result out when a newer one arrives or when it is final.
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      out_load      = 1'b0;
      if (cmd.valid && cmd_ready) begin
         if (cmd.finish && cmd.mark_end) begin
            hold_in.end_of_run = 1'b1;
         end else begin
            out_load      = hold_valid_ff;
            hold_in       = cmd.item;
            hold_valid_in = 1'b1;
         end
      end else if (hold_valid_ff && hold_ff.end_of_run && out_free) begin
         out_load      = 1'b1;
         hold_valid_in = 1'b0;
      end
      out_valid_in = out_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
      out_in       = out_load ? hold_ff : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      hold_ff <= hold_in;
      out_ff  <= out_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.out_kind    = out_ff.kind;
   assign rsp_chan.out_value   = out_ff.value;
   assign rsp_chan.end_of_run  = out_ff.end_of_run;
   assign rsp_chan.status_code = out_ff.status;

endmodule

@@ design/infix_to_postfix_converter.sv @@
// Output order: a result waits in a one-entry hold stage until the next result of its expression
// displaces it onto the port; the final result passes from the hold stage to the output register.
// Tokens are taken one at a time. An operator pops each stacked entry of equal or higher priority
// and is then pushed; a close pops operators down to its open parenthesis; the last token of an
// error-free run then flushes every stacked entry. A stalled output holds the sequencer.
// Reset (synchronous, active high) clears the stack count, depth, error and handshakes.
module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   i2p_req_if.sink    req_chan,
   i2p_rsp_if.source  rsp_chan
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);
   localparam logic [CW-1:0] ONE        = CW'(1);
   localparam logic [CW-1:0] TWO        = CW'(2);

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_DECODE    = 8'b0000_0010,
      ST_POP_CHK   = 8'b0000_0100,
      ST_AFTER_POP = 8'b0000_1000,
      ST_END_TOK   = 8'b0001_0000,
      ST_FLUSH     = 8'b0010_0000,
      ST_FLUSH_CHK = 8'b0100_0000,
      ST_FINISH    = 8'b1000_0000
   } state_type;

   state_type    state_ff, state_in;
   logic [3:0]   kind_ff, kind_in;
   logic [15:0]  value_ff, value_in;
   logic         last_ff, last_in;
   logic         emitted_ff, emitted_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] depth_ff, depth_in;
   logic [1:0]   err_ff, err_in;

   // Operator stack, one read and one write port, registered read data.
   logic [2:0]   stack_mem [STACK_DEPTH];
   logic [2:0]   rd_data_ff;
   logic         rd_en;
   logic [AW-1:0] rd_addr;
   logic         wr_en;
   logic [AW-1:0] wr_addr;
   logic [2:0]   wr_data;

   i2p_pkg::emit_cmd_type cmd;
   logic         cmd_ready;

   logic [1:0]   tok_prio;
   logic [1:0]   top_prio;
   logic         is_close;
   logic         is_operator;
   logic [CW-1:0] count_dec;
   logic [CW-1:0] count_dec2;

   assign tok_prio    = i2p_pkg::prio_of(kind_ff[2:0]);
   assign top_prio    = i2p_pkg::prio_of(rd_data_ff);
   assign is_close    = (kind_ff == i2p_pkg::KIND_CLOSE);
   assign is_operator = (kind_ff >= i2p_pkg::KIND_PLUS) && (kind_ff <= i2p_pkg::KIND_INTEGRAL);
   assign count_dec   = count_ff - ONE;
   assign count_dec2  = count_ff - TWO;

   assign req_chan.ready = (state_ff == ST_IDLE);

   // Stack memory. A push and a read never come in the same cycle, so no entry is
   // read in the cycle it is written.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   // Token sequencer.
   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      value_in   = value_ff;
      last_in    = last_ff;
      emitted_in = emitted_ff;
      count_in   = count_ff;
      depth_in   = depth_ff;
      err_in     = err_ff;
      rd_en      = 1'b0;
      rd_addr    = count_dec[AW-1:0];
      wr_en      = 1'b0;
      wr_addr    = count_ff[AW-1:0];
      wr_data    = i2p_pkg::CODE_OPEN;
      cmd        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               kind_in    = req_chan.token_kind;
               value_in   = req_chan.operand_value;
               last_in    = req_chan.last_token;
               emitted_in = 1'b0;
               state_in   = ST_DECODE;
            end
         end

         ST_DECODE: begin
            if (err_ff != i2p_pkg::STATUS_OK) begin
               state_in = ST_END_TOK;
            end else if (kind_ff == i2p_pkg::KIND_OPERAND) begin
               cmd.valid      = 1'b1;
               cmd.item.kind  = i2p_pkg::CODE_OPERAND;
               cmd.item.value = value_ff;
               if (cmd_ready) begin
                  emitted_in = 1'b1;
                  state_in   = ST_END_TOK;
               end
            end else if (is_operator || is_close) begin
               if (is_close && depth_ff == '0) begin
                  err_in   = i2p_pkg::STATUS_UNMATCHED;
                  state_in = ST_END_TOK;
               end else if (count_ff != '0) begin
                  rd_en    = 1'b1;
                  state_in = ST_POP_CHK;
               end else begin
                  state_in = ST_AFTER_POP;
               end
            end else if (kind_ff == i2p_pkg::KIND_OPEN) begin
               if (count_ff >= FULL_COUNT) begin
                  err_in = i2p_pkg::STATUS_OVERFLOW;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + ONE;
                  depth_in = depth_ff + ONE;
               end
               state_in = ST_END_TOK;
            end else begin
               state_in = ST_END_TOK;
            end
         end

         // Top of stack is in rd_data_ff: pop it or stop.
         ST_POP_CHK: begin
            if (is_close && rd_data_ff == i2p_pkg::CODE_OPEN) begin
               count_in = count_dec;
               state_in = ST_AFTER_POP;
            end else if (is_close || top_prio >= tok_prio) begin
               cmd.valid     = 1'b1;
               cmd.item.kind = rd_data_ff;
               if (cmd_ready) begin
                  emitted_in = 1'b1;
                  count_in   = count_dec;
                  if (count_dec != '0) begin
                     rd_en   = 1'b1;
                     rd_addr = count_dec2[AW-1:0];
                  end else begin
                     state_in = ST_AFTER_POP;
                  end
               end
            end else begin
               state_in = ST_AFTER_POP;
            end
         end

         // Close the parenthesis level, or push the new operator (overflow error if the stack is full).
         ST_AFTER_POP: begin
            if (is_close) begin
               depth_in = depth_ff - ONE;
            end else if (count_ff >= FULL_COUNT) begin
               err_in = i2p_pkg::STATUS_OVERFLOW;
            end else begin
               wr_en    = 1'b1;
               wr_data  = kind_ff[2:0];
               count_in = count_ff + ONE;
            end
            state_in = ST_END_TOK;
         end

         ST_END_TOK: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (err_ff == i2p_pkg::STATUS_OK && depth_ff != '0) begin
               err_in   = i2p_pkg::STATUS_UNCLOSED;
               state_in = ST_FINISH;
            end else if (err_ff == i2p_pkg::STATUS_OK) begin
               state_in = ST_FLUSH;
            end else begin
               state_in = ST_FINISH;
            end
         end

         ST_FLUSH: begin
            if (count_ff != '0) begin
               rd_en    = 1'b1;
               state_in = ST_FLUSH_CHK;
            end else begin
               state_in = ST_FINISH;
            end
         end

         // Flush pops every entry; open parentheses are dropped silently.
         ST_FLUSH_CHK: begin
            if (rd_data_ff != i2p_pkg::CODE_OPEN) begin
               cmd.valid     = 1'b1;
               cmd.item.kind = rd_data_ff;
            end
            if (rd_data_ff == i2p_pkg::CODE_OPEN || cmd_ready) begin
               if (rd_data_ff != i2p_pkg::CODE_OPEN) begin
                  emitted_in = 1'b1;
               end
               count_in = count_dec;
               if (count_dec != '0) begin
                  rd_en   = 1'b1;
                  rd_addr = count_dec2[AW-1:0];
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end

         // Mark the last result as final, or send a status record.
         ST_FINISH: begin
            cmd.valid           = 1'b1;
            cmd.finish          = 1'b1;
            cmd.mark_end        = emitted_ff && (err_ff == i2p_pkg::STATUS_OK);
            cmd.item.kind       = i2p_pkg::CODE_NONE;
            cmd.item.end_of_run = 1'b1;
            cmd.item.status     = err_ff;
            if (cmd_ready) begin
               count_in = '0;
               depth_in = '0;
               err_in   = i2p_pkg::STATUS_OK;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         depth_ff <= '0;
         err_ff   <= i2p_pkg::STATUS_OK;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         depth_ff <= depth_in;
         err_ff   <= err_in;
      end
      kind_ff    <= kind_in;
      value_ff   <= value_in;
      last_ff    <= last_in;
      emitted_ff <= emitted_in;
   end

   // Output stage.
   i2p_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_ready (cmd_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

@@ design/i2p_checker.sv @@
`include "assert_macros.svh"

// Port-level checks for the converter.
module i2p_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_kind,
   input logic [15:0] rsp_value,
   input logic        rsp_end,
   input logic [1:0]  rsp_status
);

   // A stalled result keeps its contents.
   `I2P_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_value) && $stable(rsp_end) && $stable(rsp_status))

   // Only the final result of a run carries a nonzero status.
   `I2P_ASSERT_NOW(a_status_at_end, rsp_valid && !rsp_end, rsp_status == i2p_pkg::STATUS_OK)

   // A status record is always the final result.
   `I2P_ASSERT_NOW(a_record_is_end, rsp_valid && rsp_kind == i2p_pkg::CODE_NONE, rsp_end)

   // Operators and status records carry a zero value.
   `I2P_ASSERT_NOW(a_value_zero, rsp_valid && rsp_kind != i2p_pkg::CODE_OPERAND, rsp_value == '0)

   // The converter works on one request at a time.
   `I2P_ASSERT_NEXT(a_one_request, req_valid && req_ready, !req_ready)

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_kind   (rsp_chan.out_kind),
   .rsp_value  (rsp_chan.out_value),
   .rsp_end    (rsp_chan.end_of_run),
   .rsp_status (rsp_chan.status_code)
);
